// ----- rtl/rgb_led_command_sequencer_macros.svh -----
// assertion helpers for the led command sequencer
`ifndef RGB_LED_COMMAND_SEQUENCER_MACROS_SVH
`define RGB_LED_COMMAND_SEQUENCER_MACROS_SVH

// same-cycle implication
`define RLCS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RLCS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/rlcs_pkg.sv -----
package rlcs_pkg;

	localparam int PC_W = 4;

	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_LOAD = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;
	localparam logic [1:0] KIND_SHUT = 2'd3;

	localparam logic [2:0] OPC_SHUTDOWN = 3'd0;
	localparam logic [2:0] OPC_CURRENT  = 3'd1;
	localparam logic [2:0] OPC_RED      = 3'd2;
	localparam logic [2:0] OPC_GREEN    = 3'd3;
	localparam logic [2:0] OPC_BLUE     = 3'd4;
	localparam logic [2:0] OPC_DIM_UP   = 3'd5;
	localparam logic [2:0] OPC_DIM_DOWN = 3'd6;
	localparam logic [2:0] OPC_DIM_TIME = 3'd7;

	localparam logic [7:0] WHEEL_TOP  = 8'd248;
	localparam logic [7:0] WHEEL_STEP = 8'd8;
	localparam logic [15:0] PERIOD_RESET = 16'd100;

	localparam logic [2:0] PTR_AFTER_DIM   = 3'd0;
	localparam logic [2:0] PTR_AFTER_BLUE  = 3'd1;
	localparam logic [2:0] PTR_AFTER_GREEN = 3'd2;
	localparam logic [2:0] PTR_AFTER_RED   = 3'd3;
	localparam logic [2:0] PTR_DIM_DUE     = 3'd4;

	localparam logic [2:0] PH_BLUE_DOWN  = 3'd0;
	localparam logic [2:0] PH_GREEN_UP   = 3'd1;
	localparam logic [2:0] PH_RED_DOWN   = 3'd2;
	localparam logic [2:0] PH_BLUE_UP    = 3'd3;
	localparam logic [2:0] PH_GREEN_DOWN = 3'd4;
	localparam logic [2:0] PH_RED_UP     = 3'd5;

	localparam logic [PC_W-1:0] PC_TICK = PC_W'(0);
	localparam logic [PC_W-1:0] PC_PEND = PC_W'(1);
	localparam logic [PC_W-1:0] PC_CDCK = PC_W'(2);
	localparam logic [PC_W-1:0] PC_WHEEL = PC_W'(3);
	localparam logic [PC_W-1:0] PC_CHAN = PC_W'(4);
	localparam logic [PC_W-1:0] PC_END  = PC_W'(5);
	localparam logic [PC_W-1:0] PC_LOAD = PC_W'(6);
	localparam logic [PC_W-1:0] PC_ACK  = PC_W'(7);
	localparam logic [PC_W-1:0] PC_SHUT = PC_W'(8);

	typedef enum logic [2:0] {
		UOP_NOP,
		UOP_DEC,
		UOP_WHEEL,
		UOP_CHAN,
		UOP_LOAD,
		UOP_ACK,
		UOP_SHUT
	} uop_t;

	typedef enum logic [1:0] {
		COND_NONE,
		COND_PENDING,
		COND_CD_NZ,
		COND_CHAN_MORE
	} cond_t;

	typedef struct packed {
		uop_t            op;
		cond_t           cond;
		logic [PC_W-1:0] target;
		logic            fin;
	} uword_t;

	typedef struct packed {
		logic capture;
		uop_t op;
	} ctrl_t;

	typedef struct packed {
		logic pending;
		logic cd_nz;
		logic chan_more;
		logic out_busy;
	} stat_t;

endpackage

// ----- rtl/rlcs_ucode_rom.sv -----
module rlcs_ucode_rom (
	input  logic [rlcs_pkg::PC_W-1:0] pc,
	output rlcs_pkg::uword_t          word
);
	import rlcs_pkg::*;

	always_comb begin
		case (pc)
			PC_TICK:  word = '{op: UOP_DEC,   cond: COND_NONE,      target: PC_TICK, fin: 1'b0};
			PC_PEND:  word = '{op: UOP_NOP,   cond: COND_PENDING,   target: PC_END,  fin: 1'b0};
			PC_CDCK:  word = '{op: UOP_NOP,   cond: COND_CD_NZ,     target: PC_CHAN, fin: 1'b0};
			PC_WHEEL: word = '{op: UOP_WHEEL, cond: COND_NONE,      target: PC_TICK, fin: 1'b0};
			PC_CHAN:  word = '{op: UOP_CHAN,  cond: COND_CHAN_MORE, target: PC_CHAN, fin: 1'b0};
			PC_END:   word = '{op: UOP_NOP,   cond: COND_NONE,      target: PC_TICK, fin: 1'b1};
			PC_LOAD:  word = '{op: UOP_LOAD,  cond: COND_NONE,      target: PC_TICK, fin: 1'b1};
			PC_ACK:   word = '{op: UOP_ACK,   cond: COND_NONE,      target: PC_TICK, fin: 1'b1};
			PC_SHUT:  word = '{op: UOP_SHUT,  cond: COND_NONE,      target: PC_TICK, fin: 1'b1};
			default:  word = '{op: UOP_NOP,   cond: COND_NONE,      target: PC_TICK, fin: 1'b1};
		endcase
	end

endmodule

// ----- rtl/rlcs_sequencer.sv -----
module rlcs_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [1:0]        kind,
	input  rlcs_pkg::stat_t   stat,
	output rlcs_pkg::ctrl_t   ctrl,
	output logic              busy
);
	import rlcs_pkg::*;

	logic            run_q;
	logic [PC_W-1:0] pc_q;
	uword_t          word;
	logic            hold;
	logic            taken;
	logic [PC_W-1:0] entry;

	rlcs_ucode_rom u_rom (
		.pc   (pc_q),
		.word (word)
	);

	// emitting steps wait for a free output register
	assign hold = stat.out_busy && (word.op == UOP_CHAN || word.op == UOP_SHUT);

	always_comb begin
		case (word.cond)
			COND_PENDING:   taken = stat.pending;
			COND_CD_NZ:     taken = stat.cd_nz;
			COND_CHAN_MORE: taken = stat.chan_more;
			default:        taken = 1'b0;
		endcase
	end

	always_comb begin
		case (kind)
			KIND_TICK: entry = PC_TICK;
			KIND_LOAD: entry = PC_LOAD;
			KIND_DONE: entry = PC_ACK;
			default:   entry = PC_SHUT;
		endcase
	end

	assign ctrl.capture = accept;
	assign ctrl.op      = (run_q && !hold) ? word.op : UOP_NOP;
	assign busy         = run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			pc_q  <= PC_TICK;
		end else if (accept) begin
			run_q <= 1'b1;
			pc_q  <= entry;
		end else if (run_q && !hold) begin
			if (taken) begin
				pc_q <= word.target;
			end else if (word.fin) begin
				run_q <= 1'b0;
			end else begin
				pc_q <= pc_q + PC_W'(1);
			end
		end
	end

endmodule

// ----- rtl/rlcs_datapath.sv -----
module rlcs_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  rlcs_pkg::ctrl_t ctrl,
	input  logic            period_we,
	input  logic [15:0]     period_wdata,
	input  logic [7:0]      red,
	input  logic [7:0]      green,
	input  logic [7:0]      blue,
	input  logic [4:0]      current_step,
	input  logic [7:0]      dim_time,
	input  logic            out_stall,
	output logic            out_valid,
	output logic [7:0]      out_byte,
	output rlcs_pkg::stat_t stat
);
	import rlcs_pkg::*;

	logic [15:0] period_q;
	logic        pending_q;
	logic [2:0]  ptr_q;
	logic [2:0]  phase_q;
	logic [15:0] cd_q;
	logic [7:0]  wr_red_q, wr_green_q, wr_blue_q;
	logic [4:0]  wr_cur_q;
	logic [7:0]  tg_red_q, tg_green_q, tg_blue_q;
	logic [4:0]  tg_cur_q;
	logic [7:0]  tg_dim_q;
	logic [7:0]  in_red_q, in_green_q, in_blue_q, in_dim_q;
	logic [4:0]  in_cur_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;

	logic        ch_emit;
	logic        ch_term;
	logic [7:0]  ch_byte;
	logic [2:0]  ch_ptr;
	logic        ch_wr_red, ch_wr_green, ch_wr_blue, ch_wr_cur;

	// one channel check of the round-robin walk
	always_comb begin
		ch_emit     = 1'b0;
		ch_term     = 1'b0;
		ch_byte     = {OPC_SHUTDOWN, 5'd0};
		ch_wr_red   = 1'b0;
		ch_wr_green = 1'b0;
		ch_wr_blue  = 1'b0;
		ch_wr_cur   = 1'b0;
		case (ptr_q)
			PTR_AFTER_BLUE: begin
				ch_ptr = PTR_AFTER_GREEN;
				if (wr_green_q != tg_green_q) begin
					ch_emit     = 1'b1;
					ch_wr_green = 1'b1;
					ch_byte     = {OPC_GREEN, tg_green_q[7:3]};
				end
			end
			PTR_AFTER_GREEN: begin
				ch_ptr = PTR_AFTER_RED;
				if (wr_red_q != tg_red_q) begin
					ch_emit   = 1'b1;
					ch_wr_red = 1'b1;
					ch_byte   = {OPC_BLUE, tg_red_q[7:3]};
				end
			end
			PTR_AFTER_RED: begin
				ch_ptr  = PTR_AFTER_DIM;
				ch_term = 1'b1;
				if (wr_cur_q != tg_cur_q) begin
					ch_emit   = 1'b1;
					ch_wr_cur = 1'b1;
					if (tg_dim_q == 8'd0) begin
						ch_byte = {OPC_CURRENT, tg_cur_q};
					end else begin
						ch_ptr  = PTR_DIM_DUE;
						ch_byte = {(tg_cur_q > wr_cur_q) ? OPC_DIM_UP : OPC_DIM_DOWN, tg_cur_q};
					end
				end
			end
			PTR_DIM_DUE: begin
				ch_ptr  = PTR_AFTER_DIM;
				ch_term = 1'b1;
				ch_emit = 1'b1;
				ch_byte = {OPC_DIM_TIME, tg_dim_q[7:3]};
			end
			default: begin
				ch_ptr = PTR_AFTER_BLUE;
				if (wr_blue_q != tg_blue_q) begin
					ch_emit    = 1'b1;
					ch_wr_blue = 1'b1;
					ch_byte    = {OPC_RED, tg_blue_q[7:3]};
				end
			end
		endcase
	end

	assign stat.pending   = pending_q;
	assign stat.cd_nz     = (cd_q != 16'd0);
	assign stat.chan_more = !ch_emit && !ch_term;
	assign stat.out_busy  = out_valid_q && out_stall;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			in_red_q   <= red;
			in_green_q <= green;
			in_blue_q  <= blue;
			in_cur_q   <= current_step;
			in_dim_q   <= dim_time;
		end
		if (ctrl.op == UOP_SHUT) begin
			out_byte_q <= {OPC_SHUTDOWN, 5'd0};
		end else if (ctrl.op == UOP_CHAN && ch_emit) begin
			out_byte_q <= ch_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= PERIOD_RESET;
			pending_q   <= 1'b0;
			ptr_q       <= PTR_AFTER_DIM;
			phase_q     <= PH_BLUE_DOWN;
			cd_q        <= 16'd0;
			wr_red_q    <= 8'd0;
			wr_green_q  <= 8'd0;
			wr_blue_q   <= 8'd0;
			wr_cur_q    <= 5'd0;
			tg_red_q    <= 8'd0;
			tg_green_q  <= 8'd0;
			tg_blue_q   <= 8'd0;
			tg_cur_q    <= 5'd1;
			tg_dim_q    <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (period_we) begin
				period_q <= period_wdata;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (ctrl.op)
				UOP_DEC: begin
					if (cd_q != 16'd0) begin
						cd_q <= cd_q - 16'd1;
					end
				end
				UOP_WHEEL: begin
					cd_q <= period_q;
					case (phase_q)
						PH_BLUE_DOWN: begin
							if (tg_blue_q != 8'd0) tg_blue_q <= tg_blue_q - WHEEL_STEP;
							else phase_q <= PH_GREEN_UP;
						end
						PH_GREEN_UP: begin
							if (tg_green_q != WHEEL_TOP) tg_green_q <= tg_green_q + WHEEL_STEP;
							else phase_q <= PH_RED_DOWN;
						end
						PH_RED_DOWN: begin
							if (tg_red_q != 8'd0) tg_red_q <= tg_red_q - WHEEL_STEP;
							else phase_q <= PH_BLUE_UP;
						end
						PH_BLUE_UP: begin
							if (tg_blue_q != WHEEL_TOP) tg_blue_q <= tg_blue_q + WHEEL_STEP;
							else phase_q <= PH_GREEN_DOWN;
						end
						PH_GREEN_DOWN: begin
							if (tg_green_q != 8'd0) tg_green_q <= tg_green_q - WHEEL_STEP;
							else phase_q <= PH_RED_UP;
						end
						PH_RED_UP: begin
							if (tg_red_q != WHEEL_TOP) tg_red_q <= tg_red_q + WHEEL_STEP;
							else phase_q <= PH_BLUE_DOWN;
						end
						default: begin
						end
					endcase
				end
				UOP_CHAN: begin
					ptr_q <= ch_ptr;
					if (ch_wr_red)   wr_red_q   <= tg_red_q;
					if (ch_wr_green) wr_green_q <= tg_green_q;
					if (ch_wr_blue)  wr_blue_q  <= tg_blue_q;
					if (ch_wr_cur)   wr_cur_q   <= tg_cur_q;
					if (ch_emit) begin
						out_valid_q <= 1'b1;
						pending_q   <= 1'b1;
					end
				end
				UOP_LOAD: begin
					tg_red_q   <= in_red_q;
					tg_green_q <= in_green_q;
					tg_blue_q  <= in_blue_q;
					tg_cur_q   <= in_cur_q;
					tg_dim_q   <= in_dim_q;
				end
				UOP_ACK: begin
					pending_q <= 1'b0;
				end
				UOP_SHUT: begin
					out_valid_q <= 1'b1;
					pending_q   <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- rtl/rgb_led_command_sequencer.sv -----
// rgb led command sequencer
// input channel: item_valid / item_stall with kind, red, green, blue,
//   current_step and dim_time; kind 0 tick, 1 load target, 2 transfer done,
//   3 shutdown. a word is taken when item_valid is high and item_stall low.
// output channel: cmd_valid / cmd_stall with command_byte, at most one
//   command byte per input word (ticks and shutdown only).
// rainbow_period_we writes rainbow_period_wdata, the tick count between two
//   colour wheel steps; write only while item_stall is low.
// one word at a time: item_stall stays high while the microprogram runs.
//   load, transfer done and shutdown jump to a final step; a tick
//   decrements, checks pending and countdown, may step the wheel, then
//   walks up to four channel checks, one per cycle while output is free.
// a command byte reaches cmd_valid from the shutdown step or from the
//   channel walk of a tick. it sits in an output register, so the next
//   word can be taken while it waits; a step that would emit a new command
//   waits while the previous one is stalled, holding item_stall high.
// reset: period 100, link idle, targets zero with current step one, the
//   output empty and the sequencer idle; there is no clearing pass.
module rgb_led_command_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rainbow_period_we,
	input  logic [15:0] rainbow_period_wdata,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [4:0]  current_step,
	input  logic [7:0]  dim_time,
	output logic        cmd_valid,
	input  logic        cmd_stall,
	output logic [7:0]  command_byte
);
	import rlcs_pkg::*;

	ctrl_t ctrl;
	stat_t stat;
	logic  busy;
	logic  accept;

	assign item_stall = busy;
	assign accept     = item_valid && !busy;

	rlcs_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.kind   (kind),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	rlcs_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.period_we    (rainbow_period_we),
		.period_wdata (rainbow_period_wdata),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.current_step (current_step),
		.dim_time     (dim_time),
		.out_stall    (cmd_stall),
		.out_valid    (cmd_valid),
		.out_byte     (command_byte),
		.stat         (stat)
	);

endmodule

// ----- rtl/rlcs_checker.sv -----
`include "rgb_led_command_sequencer_macros.svh"

module rlcs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_stall,
	input logic       cmd_valid,
	input logic       cmd_stall,
	input logic [7:0] command_byte
);

	`RLCS_ASSERT_NXT(a_cmd_hold, cmd_valid && cmd_stall, cmd_valid && $stable(command_byte), "stalled command changed")

	`RLCS_ASSERT_NXT(a_busy_after_accept, item_valid && !item_stall, item_stall, "not busy after accepting a word")

	`RLCS_ASSERT_IMP(a_cmd_from_work, $rose(cmd_valid), $past(item_stall), "command produced with no word at work")

endmodule

bind rgb_led_command_sequencer rlcs_checker u_chk (.*);

// ----- bench/tb_rgb_led_command_sequencer.sv -----
`timescale 1ns / 1ps

module tb_rgb_led_command_sequencer;
	import rlcs_pkg::*;

	localparam int SETTLE_CYCLES    = 20;
	localparam int LONG_HOLD        = 300;
	localparam int WATCHDOG_LIMIT   = 4000;
	localparam int RANDOM_PER_PHASE = 72;
	localparam int MAX_SHOWN        = 10;

	class led_cmd_scoreboard;
		logic [15:0]  period;
		bit           link_busy;
		logic [2:0]   ptr;
		logic [2:0]   phase;
		logic [15:0]  countdown;
		logic [7:0]   wr_r, wr_g, wr_b;
		logic [4:0]   wr_cur;
		logic [7:0]   tg_r, tg_g, tg_b;
		logic [4:0]   tg_cur;
		logic [7:0]   tg_dim;
		logic [7:0]   expected_cmds[$];
		int           n_fail;
		int           n_checked;

		function new();
			period    = PERIOD_RESET;
			link_busy = 1'b0;
			ptr       = PTR_AFTER_DIM;
			phase     = PH_BLUE_DOWN;
			countdown = '0;
			wr_r      = '0;
			wr_g      = '0;
			wr_b      = '0;
			wr_cur    = '0;
			tg_r      = '0;
			tg_g      = '0;
			tg_b      = '0;
			tg_cur    = 5'd1;
			tg_dim    = '0;
			n_fail    = 0;
			n_checked = 0;
		endfunction

		function void set_period(logic [15:0] v);
			period = v;
		endfunction

		function void step_wheel();
			case (phase)
				PH_BLUE_DOWN: if (tg_b != 8'd0) tg_b = tg_b - WHEEL_STEP; else phase = PH_GREEN_UP;
				PH_GREEN_UP: if (tg_g != WHEEL_TOP) tg_g = tg_g + WHEEL_STEP; else phase = PH_RED_DOWN;
				PH_RED_DOWN: if (tg_r != 8'd0) tg_r = tg_r - WHEEL_STEP; else phase = PH_BLUE_UP;
				PH_BLUE_UP: if (tg_b != WHEEL_TOP) tg_b = tg_b + WHEEL_STEP; else phase = PH_GREEN_DOWN;
				PH_GREEN_DOWN: if (tg_g != 8'd0) tg_g = tg_g - WHEEL_STEP; else phase = PH_RED_UP;
				PH_RED_UP: if (tg_r != WHEEL_TOP) tg_r = tg_r + WHEEL_STEP; else phase = PH_BLUE_DOWN;
				default: ;
			endcase
		endfunction

		// round-robin search for the first channel that differs from its target
		function bit walk_channels(output logic [7:0] cmd);
			cmd = '0;
			for (int i = 0; i < 5; i++) begin
				case (ptr)
					PTR_AFTER_BLUE: begin
						ptr = PTR_AFTER_GREEN;
						if (wr_g != tg_g) begin
							wr_g = tg_g;
							cmd  = {OPC_GREEN, tg_g[7:3]};
							return 1'b1;
						end
					end
					PTR_AFTER_GREEN: begin
						ptr = PTR_AFTER_RED;
						if (wr_r != tg_r) begin
							wr_r = tg_r;
							cmd  = {OPC_BLUE, tg_r[7:3]};
							return 1'b1;
						end
					end
					PTR_AFTER_RED: begin
						ptr = PTR_AFTER_DIM;
						if (wr_cur == tg_cur) return 1'b0;
						if (tg_dim == 8'd0) begin
							cmd = {OPC_CURRENT, tg_cur};
						end else begin
							ptr = PTR_DIM_DUE;
							cmd = {(tg_cur > wr_cur) ? OPC_DIM_UP : OPC_DIM_DOWN, tg_cur};
						end
						wr_cur = tg_cur;
						return 1'b1;
					end
					PTR_DIM_DUE: begin
						ptr = PTR_AFTER_DIM;
						cmd = {OPC_DIM_TIME, tg_dim[7:3]};
						return 1'b1;
					end
					default: begin
						ptr = PTR_AFTER_BLUE;
						if (wr_b != tg_b) begin
							wr_b = tg_b;
							cmd  = {OPC_RED, tg_b[7:3]};
							return 1'b1;
						end
					end
				endcase
			end
			return 1'b0;
		endfunction

		function void note_word(logic [1:0] k, logic [7:0] r, logic [7:0] g, logic [7:0] b,
				logic [4:0] c, logic [7:0] d);
			logic [7:0] cmd;
			case (k)
				KIND_TICK: begin
					if (countdown != 16'd0) countdown = countdown - 16'd1;
					if (!link_busy) begin
						if (countdown == 16'd0) begin
							countdown = period;
							step_wheel();
						end
						if (walk_channels(cmd)) begin
							expected_cmds.push_back(cmd);
							link_busy = 1'b1;
						end
					end
				end
				KIND_LOAD: begin
					tg_r   = r;
					tg_g   = g;
					tg_b   = b;
					tg_cur = c;
					tg_dim = d;
				end
				KIND_DONE: link_busy = 1'b0;
				default: begin
					link_busy = 1'b1;
					expected_cmds.push_back({OPC_SHUTDOWN, 5'd0});
				end
			endcase
		endfunction

		function void check_cmd(logic [7:0] actual);
			logic [7:0] want;
			if (expected_cmds.size() == 0) begin
				if (n_fail < MAX_SHOWN)
					$display("%0t: command byte %02h with nothing expected", $time, actual);
				n_fail++;
				return;
			end
			want = expected_cmds.pop_front();
			n_checked++;
			if (actual !== want) begin
				if (n_fail < MAX_SHOWN)
					$display("%0t: command byte expected %02h actual %02h", $time, want, actual);
				n_fail++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        rainbow_period_we;
	logic [15:0] rainbow_period_wdata;
	logic        item_valid;
	logic        item_stall;
	logic [1:0]  kind;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [4:0]  current_step;
	logic [7:0]  dim_time;
	logic        cmd_valid;
	logic        cmd_stall;
	logic [7:0]  command_byte;

	led_cmd_scoreboard sb;
	bit  tx_quiet;
	bit  rx_quiet;
	bit  hold_req;
	int  n_words;
	int  n_settings;
	int  idle_cycles;

	rgb_led_command_sequencer u_dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.rainbow_period_we    (rainbow_period_we),
		.rainbow_period_wdata (rainbow_period_wdata),
		.item_valid           (item_valid),
		.item_stall           (item_stall),
		.kind                 (kind),
		.red                  (red),
		.green                (green),
		.blue                 (blue),
		.current_step         (current_step),
		.dim_time             (dim_time),
		.cmd_valid            (cmd_valid),
		.cmd_stall            (cmd_stall),
		.command_byte         (command_byte)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] pick_level();
		int p;
		p = $urandom_range(0, 9);
		if (p < 6) return 8'($urandom_range(0, 31) * 8);
		if (p == 6) return 8'd0;
		if (p == 7) return WHEEL_TOP;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_word(input logic [1:0] k, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [4:0] c, input logic [7:0] d);
		int gap;
		gap = tx_quiet ? 0 : gap_len();
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid   <= 1'b1;
		kind         <= k;
		red          <= r;
		green        <= g;
		blue         <= b;
		current_step <= c;
		dim_time     <= d;
		do @(posedge clk); while (item_stall);
		sb.note_word(k, r, g, b, c, d);
		n_words++;
	endtask

	task automatic send_random();
		int         r;
		logic [1:0] k;
		r = $urandom_range(0, 99);
		if (r < 48) k = KIND_TICK;
		else if (r < 78) k = KIND_DONE;
		else if (r < 92) k = KIND_LOAD;
		else k = KIND_SHUT;
		if (k == KIND_LOAD)
			send_word(k, pick_level(), pick_level(), pick_level(), 5'($urandom_range(0, 31)),
				($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(0, 255)));
		else
			send_word(k, 8'($urandom), 8'($urandom), 8'($urandom), 5'($urandom), 8'($urandom));
	endtask

	task automatic release_input();
		item_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.expected_cmds.size() != 0) @(posedge clk);
	endtask

	task automatic wait_idle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	task automatic write_period(input logic [15:0] v);
		wait_idle();
		rainbow_period_we    <= 1'b1;
		rainbow_period_wdata <= v;
		@(posedge clk);
		rainbow_period_we <= 1'b0;
		sb.set_period(v);
		n_settings++;
	endtask

	// receiver side
	initial begin
		int stall_cnt;
		int hold_cnt;
		int g;
		cmd_stall = 1'b0;
		stall_cnt = 0;
		hold_cnt  = 0;
		forever begin
			@(posedge clk);
			if (hold_cnt != 0) begin
				hold_cnt--;
				cmd_stall <= 1'b1;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_cnt = LONG_HOLD - 1;
				cmd_stall <= 1'b1;
			end else if (stall_cnt != 0) begin
				stall_cnt--;
				cmd_stall <= 1'b1;
			end else if (rx_quiet) begin
				cmd_stall <= 1'b0;
			end else begin
				g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
				if (g != 0) begin
					stall_cnt = g - 1;
					cmd_stall <= 1'b1;
				end else begin
					cmd_stall <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && cmd_valid && !cmd_stall) sb.check_cmd(command_byte);
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (cmd_valid && !cmd_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d command bytes outstanding",
				$time, idle_cycles, sb.expected_cmds.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		logic [15:0] periods[6];
		sb                   = new();
		periods              = '{16'd1, 16'd0, 16'd3, 16'd2, 16'd1, 16'hFFFF};
		arst_n               = 1'b0;
		rainbow_period_we    = 1'b0;
		rainbow_period_wdata = '0;
		item_valid           = 1'b0;
		kind                 = KIND_TICK;
		red                  = '0;
		green                = '0;
		blue                 = '0;
		current_step         = '0;
		dim_time             = '0;
		tx_quiet             = 1'b0;
		rx_quiet             = 1'b0;
		hold_req             = 1'b0;
		n_words              = 0;
		n_settings           = 0;
		idle_cycles          = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset state, pending ticks, extremes, dim up, then a load back to zero
		send_word(KIND_TICK, 8'd0, 8'd0, 8'd0, 5'd0, 8'd0);
		send_word(KIND_TICK, 8'd0, 8'd0, 8'd0, 5'd0, 8'd0);
		send_word(KIND_DONE, 8'd0, 8'd0, 8'd0, 5'd0, 8'd0);
		send_word(KIND_DONE, 8'd0, 8'd0, 8'd0, 5'd0, 8'd0);
		send_word(KIND_LOAD, 8'd255, 8'd255, 8'd255, 5'd31, 8'd255);
		send_word(KIND_SHUT, 8'd0, 8'd0, 8'd0, 5'd0, 8'd0);
		send_word(KIND_TICK, 8'd0, 8'd0, 8'd0, 5'd0, 8'd0);
		send_word(KIND_DONE, 8'd0, 8'd0, 8'd0, 5'd0, 8'd0);
		repeat (5) begin
			send_word(KIND_TICK, 8'd0, 8'd0, 8'd0, 5'd0, 8'd0);
			send_word(KIND_DONE, 8'd0, 8'd0, 8'd0, 5'd0, 8'd0);
		end
		send_word(KIND_LOAD, 8'd0, 8'd0, 8'd0, 5'd0, 8'd8);
		repeat (3) begin
			send_word(KIND_TICK, 8'd0, 8'd0, 8'd0, 5'd0, 8'd0);
			send_word(KIND_DONE, 8'd0, 8'd0, 8'd0, 5'd0, 8'd0);
		end
		release_input();

		for (int i = 0; i < 6; i++) begin
			write_period(periods[i]);
			tx_quiet = (i == 1) || (i == 2);
			rx_quiet = (i == 2);
			if (i == 1) hold_req = 1'b1;
			for (int j = 0; j < RANDOM_PER_PHASE; j++) begin
				if (i == 3 && j == RANDOM_PER_PHASE / 2) begin
					release_input();
					wait_drained();
					@(posedge clk);
				end
				send_random();
			end
			release_input();
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d words and %0d command bytes over %0d period settings",
			n_words, sb.n_checked, n_settings);
		$display("periods from 0 to 65535, long receiver hold, back-to-back and idle gaps");
		if (sb.n_fail == 0 && sb.expected_cmds.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d command bytes never seen", sb.n_fail,
				sb.expected_cmds.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
